// ===== hdl/fenwick_pkg.sv =====
package fenwick_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = 11;
    localparam int WALK_W        = POS_W + 1;
    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 11;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = SIZE_W'(10);
    localparam logic [SIZE_W-1:0] SIZE_CAP          = SIZE_W'(MAX_POSITIONS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_PREFIX = 2'd1,
        OP_RANGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] delta;
        logic [POS_W-1:0]  low_end;
        logic [POS_W-1:0]  position;
        op_t               operation;
    } item_t;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] sum;
    } result_t;

    function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] v);
        return v & (~v + WALK_W'(1));
    endfunction

endpackage

// ===== hdl/fenwick_ram.sv =====
module fenwick_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/fenwick_cfg.sv =====
module fenwick_cfg
    import fenwick_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [SIZE_W-1:0] eff_size
);

    logic [SIZE_W-1:0] active_size_reg;
    logic              wr_en;

    // paddr[2] is the register index; byte lanes are ignored
    assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RESET;
        end
        else if (wr_en)
        begin
            active_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'b0)
        begin
            prdata = {{(32-SIZE_W){1'b0}}, active_size_reg};
        end
    end

    assign eff_size = (active_size_reg > SIZE_CAP) ? SIZE_CAP : active_size_reg;

endmodule

// ===== hdl/fenwick_engine.sv =====
module fenwick_engine
    import fenwick_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] eff_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             item,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    state_t              state_reg, state_next;
    logic [WALK_W-1:0]   p_reg, p_next;
    logic [POS_W-1:0]    lo_reg, lo_next;
    logic                second_reg, second_next;
    logic                sub_reg, sub_next;
    logic                pend_reg, pend_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   delta_reg, delta_next;
    logic                status_reg, status_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                clr_reply_reg, clr_reply_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                accept;
    logic                pos_ok;
    logic                lo_ok;
    logic [WALK_W-1:0]   p_up;
    logic [WALK_W-1:0]   p_down;
    logic [ADDR_W-1:0]   p_addr;
    logic                clr_last;
    logic                out_free;

    function automatic logic in_bounds(input logic [POS_W-1:0] p, input logic [SIZE_W-1:0] n);
        return (p != '0) && (p <= n);
    endfunction

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign pos_ok    = in_bounds(item.position, eff_size);
    assign lo_ok     = in_bounds(item.low_end, eff_size);
    assign p_up      = p_reg + low_bit(p_reg);
    assign p_down    = p_reg - low_bit(p_reg);
    // position p lives at address p-1
    assign p_addr    = ADDR_W'(p_reg - WALK_W'(1));
    assign clr_last  = (clr_addr_reg == ADDR_W'(MAX_POSITIONS - 1));
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (item.operation)
                        OP_ADD:    state_next = pos_ok ? ST_ADD_RD : ST_DONE;
                        OP_PREFIX: state_next = pos_ok ? ST_WALK : ST_DONE;
                        OP_RANGE:  state_next = (pos_ok && lo_ok) ? ST_WALK : ST_DONE;
                        OP_CLEAR:  state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                state_next = (p_up <= {1'b0, eff_size}) ? ST_ADD_RD : ST_DONE;
            end
            ST_WALK:
            begin
                if ((p_reg == '0) && !pend_reg && !second_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        p_next         = p_reg;
        lo_next        = lo_reg;
        second_next    = second_reg;
        sub_next       = sub_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        delta_next     = delta_reg;
        status_next    = status_reg;
        clr_addr_next  = clr_addr_reg;
        clr_reply_next = clr_reply_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = p_addr;
        mem_wdata      = mem_rdata + delta_reg;
        mem_re         = 1'b0;
        mem_raddr      = p_addr;
        in_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next         = {1'b0, item.position};
                    lo_next        = item.low_end - POS_W'(1);
                    second_next    = (item.operation == OP_RANGE);
                    sub_next       = 1'b0;
                    pend_next      = 1'b0;
                    acc_next       = '0;
                    delta_next     = item.delta;
                    clr_addr_next  = '0;
                    clr_reply_next = 1'b1;
                    unique case (item.operation)
                        OP_ADD:    status_next = !pos_ok;
                        OP_PREFIX: status_next = !pos_ok;
                        OP_RANGE:  status_next = !(pos_ok && lo_ok);
                        OP_CLEAR:  status_next = 1'b0;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                mem_re = 1'b1;
            end
            ST_ADD_WR:
            begin
                mem_we = 1'b1;
                p_next = p_up;
            end
            ST_WALK:
            begin
                // reads are issued back to back; data lands in the next cycle
                if (p_reg != '0)
                begin
                    mem_re    = 1'b1;
                    p_next    = p_down;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg && second_reg)
                    begin
                        p_next      = {1'b0, lo_reg};
                        second_next = 1'b0;
                        sub_next    = 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    acc_next = sub_reg ? (acc_reg - mem_rdata) : (acc_reg + mem_rdata);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.sum   = acc_reg;
                    out_next.status = status_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        lo_reg     <= lo_next;
        sub_reg    <= sub_next;
        acc_reg    <= acc_next;
        delta_reg  <= delta_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

// ===== hdl/fenwick_tree_prefix_sum_top.sv =====
// Operation: add visits each tree cell on its upward walk (at most 11 cells) with a read
// state and a write state per cell, prefix reads one cell per step (at most 10 cells), range
// runs two such walks, and clear zeroes the whole cell memory before replying.
// One transaction is in flight at a time, the next accepted in the cycle after the result
// is loaded, bounded by the single read and write port of the cell memory.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 1024 memory words
// with s_tready low. Configuration writes are taken throughout.
module fenwick_tree_prefix_sum_top
    import fenwick_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // position[10:0], low_end[21:11], delta[53:22]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // sum[31:0]
    output logic [0:0]  m_tuser,  // status[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SIZE_W-1:0] eff_size;
    item_t             item;
    result_t           result;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    assign item.operation = op_t'(s_tuser);
    assign item.position  = s_tdata[10:0];
    assign item.low_end   = s_tdata[21:11];
    assign item.delta     = s_tdata[53:22];

    assign m_tdata    = result.sum;
    assign m_tuser[0] = result.status;

    fenwick_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_size (eff_size)
    );

    fenwick_ram #(
        .DEPTH (MAX_POSITIONS),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fenwick_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_size  (eff_size),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule
